// ===== design/obbsat_pkg.sv =====
package obbsat_pkg;

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int DPROD_W    = DIFF_W + COORD_W;
   localparam int DMAG_W     = DPROD_W + 1;
   localparam int APROD_W    = 2 * COORD_W;
   localparam int DOT_W      = APROD_W;
   localparam int EPROD_W    = COORD_W + DOT_W;
   localparam int RAD_W      = EPROD_W + 2;
   localparam int DIST_SHIFT = 14;
   localparam int BASE_SHIFT = 28;
   localparam int NUM_AXES   = 4;

   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Z = 3'd1;
   localparam logic [2:0] REG_XAXIS_X  = 3'd2;
   localparam logic [2:0] REG_XAXIS_Z  = 3'd3;
   localparam logic [2:0] REG_ZAXIS_X  = 3'd4;
   localparam logic [2:0] REG_ZAXIS_Z  = 3'd5;
   localparam logic [2:0] REG_HALF_W   = 3'd6;
   localparam logic [2:0] REG_HALF_D   = 3'd7;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_z;
      logic signed [COORD_W-1:0] xaxis_x;
      logic signed [COORD_W-1:0] xaxis_z;
      logic signed [COORD_W-1:0] zaxis_x;
      logic signed [COORD_W-1:0] zaxis_z;
      logic [COORD_W-1:0]        half_w;
      logic [COORD_W-1:0]        half_d;
   } cfg_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dz;
      logic signed [COORD_W-1:0] p_x;
      logic signed [COORD_W-1:0] p_z;
      logic signed [COORD_W-1:0] q_x;
      logic signed [COORD_W-1:0] q_z;
      logic [COORD_W-1:0]        hp;
      logic [COORD_W-1:0]        hq;
   } box_type;

   // axis order: reference x, reference z, tested first, tested second
   typedef struct packed {
      logic [NUM_AXES-1:0][DMAG_W-1:0] dmag;
      logic [DOT_W-1:0]                ap;
      logic [DOT_W-1:0]                aq;
      logic [DOT_W-1:0]                bp;
      logic [DOT_W-1:0]                bq;
      logic [COORD_W-1:0]              hp;
      logic [COORD_W-1:0]              hq;
   } proj_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][DMAG_W-1:0] dmag;
      logic [NUM_AXES-1:0][RAD_W-1:0]  rad;
   } ext_type;

endpackage

// ===== design/obbsat_proj.sv =====
module obbsat_proj (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  obbsat_pkg::box_type  in_data,
   input  obbsat_pkg::cfg_type  cfg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output obbsat_pkg::proj_type out_data
);

   localparam int NA = obbsat_pkg::NUM_AXES;

   function automatic logic [obbsat_pkg::DMAG_W-1:0] dmag_of(
      input logic signed [obbsat_pkg::DMAG_W-1:0] v);
      return v[obbsat_pkg::DMAG_W-1] ? obbsat_pkg::DMAG_W'(-v) : obbsat_pkg::DMAG_W'(v);
   endfunction

   function automatic logic [obbsat_pkg::DOT_W-1:0] dot_of(
      input logic signed [obbsat_pkg::DOT_W:0] v);
      logic signed [obbsat_pkg::DOT_W:0] n;
      n = -v;
      return v[obbsat_pkg::DOT_W] ? n[obbsat_pkg::DOT_W-1:0] : v[obbsat_pkg::DOT_W-1:0];
   endfunction

   // stage A: products
   logic                                  a_valid_ff;
   logic                                  a_ready;
   logic signed [obbsat_pkg::DPROD_W-1:0] dpx_ff [NA];
   logic signed [obbsat_pkg::DPROD_W-1:0] dpz_ff [NA];
   logic signed [obbsat_pkg::DPROD_W-1:0] dpx_in [NA];
   logic signed [obbsat_pkg::DPROD_W-1:0] dpz_in [NA];
   logic signed [obbsat_pkg::APROD_W-1:0] apx_ff [NA];
   logic signed [obbsat_pkg::APROD_W-1:0] apz_ff [NA];
   logic signed [obbsat_pkg::APROD_W-1:0] apx_in [NA];
   logic signed [obbsat_pkg::APROD_W-1:0] apz_in [NA];
   logic [obbsat_pkg::COORD_W-1:0]        a_hp_ff;
   logic [obbsat_pkg::COORD_W-1:0]        a_hq_ff;
   logic signed [obbsat_pkg::COORD_W-1:0] ux [NA];
   logic signed [obbsat_pkg::COORD_W-1:0] uz [NA];

   // stage B: sums and magnitudes
   logic                 b_valid_ff;
   logic                 b_ready;
   obbsat_pkg::proj_type b_data_ff;
   obbsat_pkg::proj_type b_data_in;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      ux[0] = cfg.xaxis_x;
      uz[0] = cfg.xaxis_z;
      ux[1] = cfg.zaxis_x;
      uz[1] = cfg.zaxis_z;
      ux[2] = in_data.p_x;
      uz[2] = in_data.p_z;
      ux[3] = in_data.q_x;
      uz[3] = in_data.q_z;
      for (int i = 0; i < NA; i++) begin
         dpx_in[i] = in_data.dx * ux[i];
         dpz_in[i] = in_data.dz * uz[i];
      end
      // dot products: AP, AQ, BP, BQ
      apx_in[0] = in_data.p_x * cfg.xaxis_x;
      apz_in[0] = in_data.p_z * cfg.xaxis_z;
      apx_in[1] = in_data.q_x * cfg.xaxis_x;
      apz_in[1] = in_data.q_z * cfg.xaxis_z;
      apx_in[2] = in_data.p_x * cfg.zaxis_x;
      apz_in[2] = in_data.p_z * cfg.zaxis_z;
      apx_in[3] = in_data.q_x * cfg.zaxis_x;
      apz_in[3] = in_data.q_z * cfg.zaxis_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         dpx_ff  <= dpx_in;
         dpz_ff  <= dpz_in;
         apx_ff  <= apx_in;
         apz_ff  <= apz_in;
         a_hp_ff <= in_data.hp;
         a_hq_ff <= in_data.hq;
      end
   end

   always_comb begin
      logic signed [obbsat_pkg::DMAG_W-1:0] dsum;
      logic signed [obbsat_pkg::DOT_W:0]    asum [NA];
      for (int i = 0; i < NA; i++) begin
         dsum = obbsat_pkg::DMAG_W'(dpx_ff[i]) + obbsat_pkg::DMAG_W'(dpz_ff[i]);
         b_data_in.dmag[i] = dmag_of(dsum);
         asum[i] = (obbsat_pkg::DOT_W+1)'(apx_ff[i]) + (obbsat_pkg::DOT_W+1)'(apz_ff[i]);
      end
      b_data_in.ap = dot_of(asum[0]);
      b_data_in.aq = dot_of(asum[1]);
      b_data_in.bp = dot_of(asum[2]);
      b_data_in.bq = dot_of(asum[3]);
      b_data_in.hp = a_hp_ff;
      b_data_in.hq = a_hq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ===== design/obbsat_extent.sv =====
module obbsat_extent (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  obbsat_pkg::proj_type in_data,
   input  obbsat_pkg::cfg_type  cfg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output obbsat_pkg::ext_type  out_data
);

   localparam int NA   = obbsat_pkg::NUM_AXES;
   localparam int RW   = obbsat_pkg::RAD_W;
   localparam int NPRD = 2 * NA;

   // stage C: extent products
   logic                                         c_valid_ff;
   logic                                         c_ready;
   logic [obbsat_pkg::EPROD_W-1:0]               prod_ff [NPRD];
   logic [obbsat_pkg::EPROD_W-1:0]               prod_in [NPRD];
   logic [NA-1:0][obbsat_pkg::DMAG_W-1:0]        c_dmag_ff;
   logic [NA-1:0][obbsat_pkg::COORD_W-1:0]       base_ff;
   logic [NA-1:0][obbsat_pkg::COORD_W-1:0]       base_in;

   // stage D: radius sums
   logic                d_valid_ff;
   logic                d_ready;
   obbsat_pkg::ext_type d_data_ff;
   obbsat_pkg::ext_type d_data_in;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   always_comb begin
      prod_in[0] = in_data.hp * in_data.ap;
      prod_in[1] = in_data.hq * in_data.aq;
      prod_in[2] = in_data.hp * in_data.bp;
      prod_in[3] = in_data.hq * in_data.bq;
      prod_in[4] = cfg.half_w * in_data.ap;
      prod_in[5] = cfg.half_d * in_data.bp;
      prod_in[6] = cfg.half_w * in_data.aq;
      prod_in[7] = cfg.half_d * in_data.bq;
      base_in[0] = cfg.half_w;
      base_in[1] = cfg.half_d;
      base_in[2] = in_data.hp;
      base_in[3] = in_data.hq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= in_valid;
      end
      if (c_ready && in_valid) begin
         prod_ff   <= prod_in;
         c_dmag_ff <= in_data.dmag;
         base_ff   <= base_in;
      end
   end

   always_comb begin
      d_data_in.dmag = c_dmag_ff;
      for (int i = 0; i < NA; i++) begin
         d_data_in.rad[i] = (RW'(base_ff[i]) << obbsat_pkg::BASE_SHIFT)
                          + RW'(prod_ff[2*i]) + RW'(prod_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_ready && c_valid_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

// ===== design/obbsat_decide.sv =====
module obbsat_decide (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  obbsat_pkg::ext_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                overlap
);

   localparam int NA = obbsat_pkg::NUM_AXES;
   localparam int RW = obbsat_pkg::RAD_W;

   logic          valid_ff;
   logic          overlap_ff;
   logic          overlap_in;
   logic [NA-1:0] sep;

   assign in_ready = !valid_ff || out_ready;

   // strict compare: touching boxes overlap
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         sep[i] = (RW'(in_data.dmag[i]) << obbsat_pkg::DIST_SHIFT) > in_data.rad[i];
      end
      overlap_in = ~|sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         overlap_ff <= overlap_in;
      end
   end

   assign out_valid = valid_ff;
   assign overlap   = overlap_ff;

endmodule

// ===== design/obb_obb_separating_axis_test.sv =====
// 2D oriented box overlap test (separating axis method).
// The reference box sits in eight registers written over the csr channel
// (index 0..7: center x/z, x axis x/z, z axis x/z, half width, half depth).
// Writes are taken in any cycle (csr_ready is tied high) and must only
// happen while no request is in flight.
// Each request on req_ carries one tested box; one response with the
// overlap flag comes back on rsp_ per request, in order.
// Six register stages: input/offset, axis products, sums and magnitudes,
// extent products, radius sums, compare. One request per cycle is sustained
// while rsp_tready stays high.
// Each stage holds its item while the next one is full and cannot take it,
// so a stalled rsp_tready backs up stage by stage and req_tready drops only
// once all six stages hold an item. Empty stages keep filling during a stall.
// Reset empties the pipeline and loads the reference box with unit axes,
// zero center and zero extents.
module obb_obb_separating_axis_test (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // other_center_x, other_center_z, other_axis0_x, other_axis0_z,
   // other_axis1_x, other_axis1_z, other_half_w, other_half_d
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // overlap, zero pad
   output logic [7:0]   rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   localparam int CW    = obbsat_pkg::COORD_W;
   localparam int DW    = obbsat_pkg::DIFF_W;
   localparam int DEPTH = 6;

   localparam logic signed [CW-1:0] AXIS_ONE = 16'sd16384;

   obbsat_pkg::cfg_type  cfg_ff;
   obbsat_pkg::box_type  s1_data_ff;
   obbsat_pkg::box_type  s1_data_in;
   logic                 s1_valid_ff;
   logic                 s1_ready;
   logic                 proj_ready;
   logic                 proj_valid;
   obbsat_pkg::proj_type proj_data;
   logic                 ext_ready;
   logic                 ext_valid;
   obbsat_pkg::ext_type  ext_data;
   logic                 dec_ready;
   logic                 overlap;
   logic [2:0]           inflight_ff;
   logic [2:0]           inflight_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x <= '0;
         cfg_ff.center_z <= '0;
         cfg_ff.xaxis_x  <= AXIS_ONE;
         cfg_ff.xaxis_z  <= '0;
         cfg_ff.zaxis_x  <= '0;
         cfg_ff.zaxis_z  <= AXIS_ONE;
         cfg_ff.half_w   <= '0;
         cfg_ff.half_d   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            obbsat_pkg::REG_CENTER_X: cfg_ff.center_x <= csr_data;
            obbsat_pkg::REG_CENTER_Z: cfg_ff.center_z <= csr_data;
            obbsat_pkg::REG_XAXIS_X:  cfg_ff.xaxis_x  <= csr_data;
            obbsat_pkg::REG_XAXIS_Z:  cfg_ff.xaxis_z  <= csr_data;
            obbsat_pkg::REG_ZAXIS_X:  cfg_ff.zaxis_x  <= csr_data;
            obbsat_pkg::REG_ZAXIS_Z:  cfg_ff.zaxis_z  <= csr_data;
            obbsat_pkg::REG_HALF_W:   cfg_ff.half_w   <= csr_data;
            obbsat_pkg::REG_HALF_D:   cfg_ff.half_d   <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: center offset
   always_comb begin
      s1_data_in.dx  = DW'($signed(req_tdata[0*CW +: CW])) - DW'(cfg_ff.center_x);
      s1_data_in.dz  = DW'($signed(req_tdata[1*CW +: CW])) - DW'(cfg_ff.center_z);
      s1_data_in.p_x = req_tdata[2*CW +: CW];
      s1_data_in.p_z = req_tdata[3*CW +: CW];
      s1_data_in.q_x = req_tdata[4*CW +: CW];
      s1_data_in.q_z = req_tdata[5*CW +: CW];
      s1_data_in.hp  = req_tdata[6*CW +: CW];
      s1_data_in.hq  = req_tdata[7*CW +: CW];
   end

   assign s1_ready   = !s1_valid_ff || proj_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (s1_ready && req_tvalid) begin
         s1_data_ff <= s1_data_in;
      end
   end

   obbsat_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (proj_ready),
      .in_data   (s1_data_ff),
      .cfg       (cfg_ff),
      .out_valid (proj_valid),
      .out_ready (ext_ready),
      .out_data  (proj_data)
   );

   obbsat_extent u_extent (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .in_ready  (ext_ready),
      .in_data   (proj_data),
      .cfg       (cfg_ff),
      .out_valid (ext_valid),
      .out_ready (dec_ready),
      .out_data  (ext_data)
   );

   obbsat_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ext_valid),
      .in_ready  (dec_ready),
      .in_data   (ext_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .overlap   (overlap)
   );

   assign rsp_tdata = {7'b0, overlap};

   // requests in flight
   assign inflight_in = inflight_ff + 3'(req_tvalid && req_tready)
                      - 3'(rsp_tvalid && rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'(DEPTH))
      else $error("more requests in flight than pipeline stages");

   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != 3'd0)
      else $error("response without a pending request");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == 3'd0 |-> req_tready)
      else $error("empty pipeline refuses a request");

endmodule
